>>> rtl/button_press_qualifier_core_defines.svh
// assertion macros for the button press qualifier
// used by the top level only, no other dependencies
`ifndef BUTTON_PRESS_QUALIFIER_CORE_DEFINES_SVH
`define BUTTON_PRESS_QUALIFIER_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpq assertion failed");
// next-cycle implication
`define BPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpq assertion failed");
`else
`define BPQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BPQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/bpq_pkg.sv
// types and constants shared by the button press qualifier
// no dependencies
package bpq_pkg;

    localparam int TIME_W = 32;
    localparam int MS_W   = 16;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESSED = 2'd1,
        EV_LONG    = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        REG_LONG_PRESS_ENABLE  = 2'd0,
        REG_LONG_PRESS_MS      = 2'd1,
        REG_REPEAT_INTERVAL_MS = 2'd2,
        REG_DEBOUNCE_MS        = 2'd3
    } t_reg_index;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CFG_ERR = 1'b1;

    localparam logic            RST_LONG_PRESS_ENABLE  = 1'b0;
    localparam logic [MS_W-1:0] RST_LONG_PRESS_MS      = 16'd1000;
    localparam logic [MS_W-1:0] RST_REPEAT_INTERVAL_MS = 16'd500;
    localparam logic [MS_W-1:0] RST_DEBOUNCE_MS        = 16'd200;

    typedef struct packed {
        logic            long_press_enable;
        logic [MS_W-1:0] long_press_ms;
        logic [MS_W-1:0] repeat_interval_ms;
        logic [MS_W-1:0] debounce_ms;
    } t_cfg;

    typedef struct packed {
        logic              prev_level;
        logic [TIME_W-1:0] fall_time;
        logic              long_active;
    } t_state;

    typedef struct packed {
        t_event event_code;
        logic   level_seen;
        logic   status;
    } t_result;

endpackage

>>> rtl/bpq_in_if.sv
// request channel of the button press qualifier: timestamp and pin level
// depends on bpq_pkg
interface bpq_in_if
    import bpq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_ms;
    logic              pin_level;

    modport source (output valid, output now_ms, output pin_level, input ready);
    modport sink   (input valid, input now_ms, input pin_level, output ready);
endinterface

>>> rtl/bpq_out_if.sv
// result channel of the button press qualifier
// depends on bpq_pkg
interface bpq_out_if
    import bpq_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;
    logic       level_seen;
    logic       status;

    modport source (output valid, output event_code, output level_seen, output status,
                    input ready);
    modport sink   (input valid, input event_code, input level_seen, input status,
                    output ready);
endinterface

>>> rtl/button_press_qualifier_core.sv
// button press qualifier: debounce, long press and auto-repeat for one button
// the result is registered: it is valid in the cycle after request acceptance
// throughput: one request per cycle, limited only by the output register
// ready is high while the output register is empty or being drained
// reset (synchronous, active low) sets state and config to defaults, clears result valid
// depends on bpq_pkg, bpq_in_if, bpq_out_if, bpq_eval and the assertion header
`include "button_press_qualifier_core_defines.svh"

module button_press_qualifier_core
    import bpq_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    bpq_in_if.sink          i_req,
    bpq_out_if.source       o_res,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [MS_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    req_acc;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign req_acc     = i_req.valid && i_req.ready;

    bpq_eval u_eval (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_now_ms    (i_req.now_ms),
        .i_pin_level (i_req.pin_level),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_enable  <= RST_LONG_PRESS_ENABLE;
            r_cfg.long_press_ms      <= RST_LONG_PRESS_MS;
            r_cfg.repeat_interval_ms <= RST_REPEAT_INTERVAL_MS;
            r_cfg.debounce_ms        <= RST_DEBOUNCE_MS;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_LONG_PRESS_ENABLE:  r_cfg.long_press_enable  <= i_cfg_data[0];
                REG_LONG_PRESS_MS:      r_cfg.long_press_ms      <= i_cfg_data;
                REG_REPEAT_INTERVAL_MS: r_cfg.repeat_interval_ms <= i_cfg_data;
                REG_DEBOUNCE_MS:        r_cfg.debounce_ms        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.prev_level  <= 1'b1;
            r_state.fall_time   <= '0;
            r_state.long_active <= 1'b0;
        end else if (req_acc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_result <= n_result;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.event_code = r_result.event_code;
    assign o_res.level_seen = r_result.level_seen;
    assign o_res.status     = r_result.status;

    // error results carry no event and no level
    `BPQ_ASSERT_IMP(a_err_result_clean, i_clk, i_rst_n, r_out_valid && (r_result.status == STATUS_CFG_ERR), (r_result.event_code == EV_NONE) && !r_result.level_seen)
    // an error request leaves the button state alone
    `BPQ_ASSERT_NXT(a_err_keeps_state, i_clk, i_rst_n, req_acc && (n_result.status == STATUS_CFG_ERR), $stable(r_state.fall_time) && $stable(r_state.prev_level) && $stable(r_state.long_active))
    // a reported long press means one is running
    `BPQ_ASSERT_IMP(a_long_sets_flag, i_clk, i_rst_n, r_out_valid && (r_result.event_code == EV_LONG), r_state.long_active)

endmodule

>>> rtl/bpq_eval.sv
// per-request decision logic: next state and result from state, config and sample
// depends on bpq_pkg
module bpq_eval
    import bpq_pkg::*;
(
    input  t_cfg              i_cfg,
    input  t_state            i_state,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_pin_level,
    output t_state            o_state,
    output t_result           o_result
);

    logic              cfg_err;
    logic [MS_W-1:0]   interval;
    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] debounce_ext;
    logic [TIME_W-1:0] long_ext;
    logic [TIME_W-1:0] interval_ext;

    assign cfg_err  = i_cfg.long_press_enable && (i_cfg.long_press_ms < i_cfg.debounce_ms);
    assign interval = (i_cfg.repeat_interval_ms < i_cfg.debounce_ms) ?
                      i_cfg.debounce_ms : i_cfg.repeat_interval_ms;
    // wraps modulo 2^32
    assign diff         = i_now_ms - i_state.fall_time;
    assign debounce_ext = {{(TIME_W-MS_W){1'b0}}, i_cfg.debounce_ms};
    assign long_ext     = {{(TIME_W-MS_W){1'b0}}, i_cfg.long_press_ms};
    assign interval_ext = {{(TIME_W-MS_W){1'b0}}, interval};

    always_comb begin
        o_state             = i_state;
        o_result.event_code = EV_NONE;
        o_result.level_seen = i_pin_level;
        o_result.status     = STATUS_OK;
        if (cfg_err) begin
            o_result.level_seen = 1'b0;
            o_result.status     = STATUS_CFG_ERR;
        end else begin
            if (i_state.prev_level && !i_pin_level) begin
                o_state.fall_time = i_now_ms;
            end else if (!i_state.prev_level && i_pin_level) begin
                if (diff > debounce_ext) begin
                    // a release after a long press only ends it
                    if (i_state.long_active) begin
                        o_state.long_active = 1'b0;
                    end else begin
                        o_result.event_code = EV_PRESSED;
                    end
                end
            end else if (!i_state.prev_level && !i_pin_level) begin
                if (i_cfg.long_press_enable) begin
                    if ((diff >= long_ext) && !i_state.long_active) begin
                        o_state.long_active = 1'b1;
                        o_result.event_code = EV_LONG;
                    end
                end else if (diff > interval_ext) begin
                    // auto-repeat restarts timing on each report
                    o_result.event_code = EV_PRESSED;
                    o_state.fall_time   = i_now_ms;
                end
            end
            o_state.prev_level = i_pin_level;
        end
    end

endmodule

>>> tb/bpq_result_checker.sv
`timescale 1ns / 100ps
// result checker for the button press qualifier: watches both channels and the
// register port, predicts each result and compares it; depends on bpq_pkg
module bpq_result_checker
    import bpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_pin_level,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [1:0]        i_event_code,
    input  logic              i_level_seen,
    input  logic              i_status,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [MS_W-1:0]   i_cfg_data,
    output int                o_errors,
    output int                o_pending
);

    t_cfg    cfg_q;
    t_state  button_q;
    t_result predicted_events[$];
    int      mismatches;

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatches++;
    endtask

    // one sample through debounce, long press and auto-repeat
    function automatic t_result qualify_sample(input logic [TIME_W-1:0] stamp,
                                               input logic level);
        t_result           r;
        logic [MS_W-1:0]   interval;
        logic [TIME_W-1:0] held;
        r.event_code = EV_NONE;
        r.level_seen = level;
        r.status     = STATUS_OK;
        if (cfg_q.long_press_enable && cfg_q.long_press_ms < cfg_q.debounce_ms) begin
            r.level_seen = 1'b0;
            r.status     = STATUS_CFG_ERR;
            return r;
        end
        interval = (cfg_q.repeat_interval_ms < cfg_q.debounce_ms) ?
                   cfg_q.debounce_ms : cfg_q.repeat_interval_ms;
        held = stamp - button_q.fall_time;
        if (button_q.prev_level && !level) begin
            button_q.fall_time = stamp;
        end else if (!button_q.prev_level && level) begin
            if (held > TIME_W'(cfg_q.debounce_ms)) begin
                if (button_q.long_active) begin
                    button_q.long_active = 1'b0;
                end else begin
                    r.event_code = EV_PRESSED;
                end
            end
        end else if (!button_q.prev_level && !level) begin
            if (cfg_q.long_press_enable) begin
                if (held >= TIME_W'(cfg_q.long_press_ms) && !button_q.long_active) begin
                    button_q.long_active = 1'b1;
                    r.event_code         = EV_LONG;
                end
            end else if (held > TIME_W'(interval)) begin
                // auto-repeat restarts the hold timing
                r.event_code       = EV_PRESSED;
                button_q.fall_time = stamp;
            end
        end
        button_q.prev_level = level;
        return r;
    endfunction

    task automatic check_result();
        t_result want;
        if (predicted_events.size() == 0) begin
            report_mismatch("result with no request outstanding");
            return;
        end
        want = predicted_events.pop_front();
        if (i_event_code !== want.event_code)
            report_mismatch($sformatf("event_code got %0d want %0d",
                                      i_event_code, want.event_code));
        if (i_level_seen !== want.level_seen)
            report_mismatch($sformatf("level_seen got %b want %b",
                                      i_level_seen, want.level_seen));
        if (i_status !== want.status)
            report_mismatch($sformatf("status got %b want %b", i_status, want.status));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_q.long_press_enable  = RST_LONG_PRESS_ENABLE;
            cfg_q.long_press_ms      = RST_LONG_PRESS_MS;
            cfg_q.repeat_interval_ms = RST_REPEAT_INTERVAL_MS;
            cfg_q.debounce_ms        = RST_DEBOUNCE_MS;
            button_q.prev_level      = 1'b1;
            button_q.fall_time       = '0;
            button_q.long_active     = 1'b0;
            predicted_events.delete();
        end else begin
            if (i_res_valid && i_res_ready)
                check_result();
            if (i_req_valid && i_req_ready)
                predicted_events.push_back(qualify_sample(i_now_ms, i_pin_level));
            if (i_cfg_we) begin
                case (t_reg_index'(i_cfg_index))
                    REG_LONG_PRESS_ENABLE:  cfg_q.long_press_enable  = i_cfg_data[0];
                    REG_LONG_PRESS_MS:      cfg_q.long_press_ms      = i_cfg_data;
                    REG_REPEAT_INTERVAL_MS: cfg_q.repeat_interval_ms = i_cfg_data;
                    REG_DEBOUNCE_MS:        cfg_q.debounce_ms        = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = predicted_events.size();
        o_errors  = mismatches;
    end

endmodule

>>> tb/button_press_qualifier_core_test.sv
`timescale 1ns / 100ps
// top of the button press qualifier testbench: clock, reset, requests,
// result back-pressure and verdict; depends on bpq_pkg, the channel
// interfaces, the core and bpq_result_checker
module button_press_qualifier_core_test;
    import bpq_pkg::*;

    localparam int HOLD_OFF_CYCLES = 40;

    logic            i_clk;
    logic            i_rst_n;
    logic            cfg_we;
    logic [1:0]      cfg_index;
    logic [MS_W-1:0] cfg_data;
    int              errors;
    int              pending;

    bpq_in_if  u_req ();
    bpq_out_if u_res ();

    button_press_qualifier_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (u_req),
        .o_res       (u_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bpq_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (u_req.valid),
        .i_req_ready  (u_req.ready),
        .i_now_ms     (u_req.now_ms),
        .i_pin_level  (u_req.pin_level),
        .i_res_valid  (u_res.valid),
        .i_res_ready  (u_res.ready),
        .i_event_code (u_res.event_code),
        .i_level_seen (u_res.level_seen),
        .i_status     (u_res.status),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    // current register setting, mirrored for shaping the hold times
    int                cur_long;
    int                cur_rep;
    int                cur_deb;
    logic [TIME_W-1:0] clock_ms;
    int                items_sent;
    bit                no_idle;
    bit                sender_burst;
    int                hold_requests;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side back-pressure
    initial begin
        int unsigned wait_cycles;
        int          holds_done;
        u_res.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            wait_cycles = no_idle ? 0 : $urandom_range(0, 13);
            if (hold_requests != holds_done) begin
                wait_cycles = wait_cycles + HOLD_OFF_CYCLES;
                holds_done++;
            end
            if (wait_cycles != 0) begin
                u_res.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            u_res.ready <= 1'b1;
            @(posedge i_clk);
            while (!u_res.valid) @(posedge i_clk);
        end
    end

    task automatic send_item(input logic [TIME_W-1:0] stamp, input logic level);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            u_req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        u_req.valid     <= 1'b1;
        u_req.now_ms    <= stamp;
        u_req.pin_level <= level;
        @(posedge i_clk);
        while (!u_req.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        u_req.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_register(input t_reg_index idx, input logic [MS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic en, input int long_ms, input int rep_ms,
                                 input int deb_ms);
        drain();
        write_register(REG_LONG_PRESS_ENABLE, MS_W'(en));
        write_register(REG_LONG_PRESS_MS, MS_W'(long_ms));
        write_register(REG_REPEAT_INTERVAL_MS, MS_W'(rep_ms));
        write_register(REG_DEBOUNCE_MS, MS_W'(deb_ms));
        cfg_we       <= 1'b0;
        cur_long     = long_ms;
        cur_rep      = rep_ms;
        cur_deb      = deb_ms;
        clock_ms     = $urandom;
        no_idle      = ($urandom_range(0, 3) == 0);
        sender_burst = no_idle;
    endtask

    // time step between samples, often landing right on a threshold
    function automatic logic [TIME_W-1:0] pick_span();
        int unsigned pick;
        int          base;
        int          reach;
        reach = (cur_rep < cur_deb) ? cur_deb : cur_rep;
        if (cur_long > reach)
            reach = cur_long;
        pick = $urandom_range(0, 9);
        case (pick)
            0: base = cur_deb;
            1: base = cur_long;
            2: base = (cur_rep < cur_deb) ? cur_deb : cur_rep;
            3: return '0;
            default: return $urandom_range(0, 2 * reach + 4);
        endcase
        base = base + int'($urandom_range(0, 2)) - 1;
        if (base < 0)
            base = 0;
        return base;
    endfunction

    // press, hold for a few samples, release
    task automatic press_cycle();
        int unsigned held_samples;
        if ($urandom_range(0, 2) == 0) begin
            clock_ms += pick_span();
            send_item(clock_ms, 1'b1);
        end
        clock_ms += pick_span();
        send_item(clock_ms, 1'b0);
        held_samples = $urandom_range(0, 4);
        repeat (held_samples) begin
            clock_ms += pick_span();
            send_item(clock_ms, 1'b0);
        end
        clock_ms += pick_span();
        send_item(clock_ms, 1'b1);
    endtask

    task automatic run_random(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(0, 9) < 2)
                send_item($urandom, 1'($urandom_range(0, 1)));
            else
                press_cycle();
        end
    endtask

    initial begin
        logic [TIME_W-1:0] base_ms;
        i_rst_n         <= 1'b0;
        u_req.valid     <= 1'b0;
        u_req.now_ms    <= '0;
        u_req.pin_level <= 1'b1;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_LONG_PRESS_ENABLE;
        cfg_data        <= '0;
        items_sent    = 0;
        no_idle       = 1'b0;
        sender_burst  = 1'b0;
        hold_requests = 0;
        cur_long      = int'(RST_LONG_PRESS_MS);
        cur_rep       = int'(RST_REPEAT_INTERVAL_MS);
        cur_deb       = int'(RST_DEBOUNCE_MS);
        clock_ms      = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: steady high, debounce edge, auto-repeat, wrap of time
        send_item(32'h0000_0000, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'd100, 1'b0);
        send_item(32'd300, 1'b1);
        send_item(32'd400, 1'b0);
        send_item(32'd601, 1'b1);
        send_item(32'd1000, 1'b0);
        send_item(32'd1500, 1'b0);
        send_item(32'd1501, 1'b0);
        send_item(32'd2002, 1'b0);
        send_item(32'd2100, 1'b1);
        send_item(32'hFFFF_FF00, 1'b0);
        send_item(32'h0000_0010, 1'b1);
        send_item(32'd5000, 1'b1);
        hold_requests++;
        run_random(50);

        // long press reported once, release only ends it
        apply_setting(1'b1, 300, 20, 50);
        base_ms = 32'h8000_0000;
        send_item(base_ms, 1'b0);
        send_item(base_ms + 299, 1'b0);
        send_item(base_ms + 300, 1'b0);
        send_item(base_ms + 400, 1'b0);
        send_item(base_ms + 500, 1'b1);
        send_item(base_ms + 600, 1'b0);
        send_item(base_ms + 651, 1'b1);
        run_random(50);

        // long press shorter than debounce
        apply_setting(1'b1, 100, 500, 200);
        send_item(32'd10, 1'b0);
        send_item(32'd5000, 1'b1);
        run_random(25);

        // repeat interval below debounce
        apply_setting(1'b0, 1000, 100, 200);
        run_random(60);

        apply_setting(1'b0, 0, 0, 0);
        run_random(50);

        apply_setting(1'b1, 65535, 65535, 65535);
        run_random(50);

        apply_setting(1'b1, 0, 0, 0);
        run_random(40);

        // receiver holds off while requests keep coming
        apply_setting(1'b0, 0, 65535, 10);
        sender_burst = 1'b1;
        hold_requests++;
        run_random(50);

        drain();
        repeat (4) @(negedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
